// ----- rtl/rcs_pkg.sv -----
`timescale 1ns / 1ps

package rcs_pkg;

  localparam int unsigned MaxLineDefault = 4096;
  localparam int unsigned LineLengthW    = 13;
  localparam logic [LineLengthW-1:0] LineLengthReset = 13'd640;
  localparam int unsigned PixelW         = 8;
  localparam int unsigned MidDepth       = 4;
  localparam int unsigned OutDepth       = 4;
  localparam int unsigned ApbAddrW       = 2;
  localparam int unsigned ApbDataW       = 32;

  localparam logic [ApbAddrW-1:0] AddrLineLength = 2'd0;
  localparam logic ActPad = 1'b1;

  typedef struct packed {
    logic              action;
    logic [PixelW-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PixelW-1:0] edge_value;
    logic              end_of_line;
    logic              end_of_frame;
    logic              last_of_run;
  } out_item_t;

  // One classified sample on its way from the front to the back.
  typedef struct packed {
    logic [PixelW-1:0] cur_px;
    logic [PixelW-1:0] left_px;
    logic [PixelW-1:0] above_px;
    logic              has_mid;
    logic              has_end;
    logic              row_end;
    logic              frame_end;
  } rec_t;

  function automatic logic [PixelW-1:0] abs_diff(input logic [PixelW-1:0] x,
                                                 input logic [PixelW-1:0] y);
    abs_diff = (x > y) ? (x - y) : (y - x);
  endfunction

  function automatic logic [PixelW-1:0] sat8(input logic [PixelW:0] x);
    sat8 = x[PixelW] ? {PixelW{1'b1}} : x[PixelW-1:0];
  endfunction

endpackage

// ----- rtl/rcs_front.sv -----
`timescale 1ns / 1ps

module rcs_front #(
  parameter int unsigned MaxLine = rcs_pkg::MaxLineDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  rcs_pkg::in_item_t                  item_i,
  input  logic [rcs_pkg::LineLengthW-1:0]    line_length_i,
  output logic                               rec_valid_o,
  output rcs_pkg::rec_t                      rec_o
);

  localparam int unsigned ColW = (MaxLine > 1) ? $clog2(MaxLine) : 1;
  localparam int unsigned LenW = $clog2(MaxLine + 1);
  localparam int unsigned CmpW = (LenW > rcs_pkg::LineLengthW) ? LenW : rcs_pkg::LineLengthW;

  logic [ColW-1:0]                col_q, col_d, col;
  logic                           frd_q, frd_d;
  logic                           prs_q, prs_d;
  logic [rcs_pkg::PixelW-1:0]     left_q, left_d;
  logic                           s1_valid_q;
  rcs_pkg::rec_t                  s1_rec_q, s1_rec_d;
  logic [rcs_pkg::PixelW-1:0]     above_q;
  logic [rcs_pkg::PixelW-1:0]     store_q [MaxLine];

  logic [CmpW-1:0]                len_ext, len_eff, last_col;
  logic                           row_end, prs_new;
  logic [rcs_pkg::PixelW-1:0]     cur;

  always_comb begin
    len_ext = CmpW'(line_length_i);
    if (len_ext == '0) begin
      len_eff = CmpW'(1);
    end else if (len_ext > CmpW'(MaxLine)) begin
      len_eff = CmpW'(MaxLine);
    end else begin
      len_eff = len_ext;
    end
    last_col = len_eff - CmpW'(1);
    row_end  = CmpW'(col_q) >= last_col;
    col      = row_end ? last_col[ColW-1:0] : col_q;
    cur      = (item_i.action == rcs_pkg::ActPad) ? '0 : item_i.pixel_value;
    prs_new  = prs_q | (item_i.action == rcs_pkg::ActPad);

    s1_rec_d.cur_px    = cur;
    s1_rec_d.left_px   = left_q;
    s1_rec_d.above_px  = '0;
    s1_rec_d.has_mid   = frd_q && (col != '0);
    s1_rec_d.has_end   = frd_q && row_end;
    s1_rec_d.row_end   = row_end;
    s1_rec_d.frame_end = prs_new;

    col_d  = col_q;
    frd_d  = frd_q;
    prs_d  = prs_q;
    left_d = left_q;
    if (accept_i) begin
      left_d = cur;
      if (row_end) begin
        col_d = '0;
        frd_d = !prs_new;
        prs_d = 1'b0;
      end else begin
        col_d = col + ColW'(1);
        prs_d = prs_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      frd_q      <= 1'b0;
      prs_q      <= 1'b0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      frd_q      <= frd_d;
      prs_q      <= prs_d;
      left_q     <= left_d;
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_rec_q <= s1_rec_d;
    end
  end

  // The store is read before it is written, so the old row's sample comes back.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      above_q     <= store_q[col];
      store_q[col] <= cur;
    end
  end

  always_comb begin
    rec_o          = s1_rec_q;
    rec_o.above_px = above_q;
  end

  assign rec_valid_o = s1_valid_q;

endmodule

// ----- rtl/rcs_mid_fifo.sv -----
`timescale 1ns / 1ps

module rcs_mid_fifo (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  input  rcs_pkg::rec_t                          data_i,
  input  logic                                   pop_i,
  output rcs_pkg::rec_t                          data_o,
  output logic                                   empty_o,
  output logic [$clog2(rcs_pkg::MidDepth+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(rcs_pkg::MidDepth);
  localparam int unsigned CntW = $clog2(rcs_pkg::MidDepth + 1);

  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  rcs_pkg::rec_t   mem_q [rcs_pkg::MidDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

// ----- rtl/rcs_back.sv -----
`timescale 1ns / 1ps

module rcs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rec_valid_i,
  input  rcs_pkg::rec_t      rec_i,
  output logic               rec_pop_o,
  input  logic               pop_i,
  output rcs_pkg::out_item_t result_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = $clog2(rcs_pkg::OutDepth);
  localparam int unsigned CntW = $clog2(rcs_pkg::OutDepth + 1);
  localparam int unsigned PW   = rcs_pkg::PixelW;

  logic [PW-1:0]      ul_q;
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    cnt_q;
  rcs_pkg::out_item_t mem_q [rcs_pkg::OutDepth];

  rcs_pkg::out_item_t mid_item, end_item, entry0;
  logic               rec_pop, out_pop, wr0, wr1;
  logic [CntW-1:0]    n_push;

  assign rec_pop = rec_valid_i && (cnt_q <= CntW'(rcs_pkg::OutDepth - 2));
  assign out_pop = pop_i && (cnt_q != '0);

  always_comb begin
    mid_item.edge_value   = rcs_pkg::sat8((PW+1)'(rcs_pkg::abs_diff(ul_q, rec_i.cur_px))
                          + (PW+1)'(rcs_pkg::abs_diff(rec_i.above_px, rec_i.left_px)));
    mid_item.end_of_line  = 1'b0;
    mid_item.end_of_frame = 1'b0;
    mid_item.last_of_run  = !rec_i.row_end;

    end_item.edge_value   = rcs_pkg::sat8((PW+1)'(rec_i.above_px) + (PW+1)'(rec_i.cur_px));
    end_item.end_of_line  = 1'b1;
    end_item.end_of_frame = rec_i.frame_end;
    end_item.last_of_run  = 1'b1;

    entry0 = rec_i.has_mid ? mid_item : end_item;
    wr0    = rec_pop && (rec_i.has_mid || rec_i.has_end);
    wr1    = rec_pop && rec_i.has_mid && rec_i.has_end;
    n_push = CntW'(wr0) + CntW'(wr1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ul_q     <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (rec_pop) begin
        ul_q <= rec_i.above_px;
      end
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + n_push - CntW'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr0) begin
      mem_q[wr_ptr_q] <= entry0;
    end
    if (wr1) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= end_item;
    end
  end

  assign rec_pop_o = rec_pop;
  assign result_o  = mem_q[rd_ptr_q];
  assign empty_o   = (cnt_q == '0);

endmodule

// ----- rtl/roberts_cross_edge_stream.sv -----
`timescale 1ns / 1ps

// Roberts cross edge detector for a raster stream of 8-bit samples.
// Samples enter through a queue-style port: an item transfers when push is
// high and full is low. Results leave the same way: the oldest result sits on
// result_o while empty is low and transfers when pop is high.
// The first row of a frame only fills the line store. Each later sample but
// the first of its row gives a result, and the last sample of a row adds a line-end result. A row
// containing pad items closes the frame and marks its final result.
// The line length register sits at address 0 of the APB port; write it only
// while the block is idle. pready is always high.
// One sample is taken every clock while full is low. Its record passes the
// front stage register and both queues; the single-port line store is read and
// written in the same cycle, which sets the one-sample-per-clock figure.
// Reset clears the column counter, frame flags and both queues, and sets the
// line length to 640. The line store is not cleared.
// When the receiver stalls, the result queue takes records only while at least two of
// its four entries are free, the four-entry queue between the front and back
// then fills, and full rises.

module roberts_cross_edge_stream #(
  parameter int unsigned MaxLine = rcs_pkg::MaxLineDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  rcs_pkg::in_item_t             item_i,
  output logic                          empty,
  input  logic                          pop,
  output rcs_pkg::out_item_t            result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rcs_pkg::ApbAddrW-1:0]  paddr,
  input  logic [rcs_pkg::ApbDataW-1:0]  pwdata,
  output logic [rcs_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned CntW = $clog2(rcs_pkg::MidDepth + 1);

  logic [rcs_pkg::LineLengthW-1:0] line_length_q;
  logic                            accept, rec_valid, rec_pop, mid_empty;
  rcs_pkg::rec_t                   front_rec, mid_rec;
  logic [CntW-1:0]                 mid_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= rcs_pkg::LineLengthReset;
    end else if (psel && penable && pwrite && (paddr == rcs_pkg::AddrLineLength)) begin
      line_length_q <= pwdata[rcs_pkg::LineLengthW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == rcs_pkg::AddrLineLength) ?
                  rcs_pkg::ApbDataW'(line_length_q) : '0;

  assign full   = ((CntW+1)'(mid_cnt) + (CntW+1)'(rec_valid)) >= (CntW+1)'(rcs_pkg::MidDepth);
  assign accept = push && !full;

  rcs_front #(
    .MaxLine(MaxLine)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (item_i),
    .line_length_i (line_length_q),
    .rec_valid_o   (rec_valid),
    .rec_o         (front_rec)
  );

  rcs_mid_fifo u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_valid),
    .data_i  (front_rec),
    .pop_i   (rec_pop),
    .data_o  (mid_rec),
    .empty_o (mid_empty),
    .count_o (mid_cnt)
  );

  rcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (!mid_empty),
    .rec_i       (mid_rec),
    .rec_pop_o   (rec_pop),
    .pop_i       (pop),
    .result_o    (result_o),
    .empty_o     (empty)
  );

endmodule

// ----- rtl/rcs_checker.sv -----
`timescale 1ns / 1ps

module rcs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input rcs_pkg::out_item_t result_i
);

  a_empty_after_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("Result queue is not empty as reset is released.");

  a_eof_is_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_i.end_of_frame) |-> result_i.end_of_line)
    else $error("End of frame without end of line.");

  a_eol_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_i.end_of_line) |-> result_i.last_of_run)
    else $error("Line end result is not the last of its run.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_i)))
    else $error("Stalled result changed before its transfer.");

endmodule

bind roberts_cross_edge_stream rcs_checker u_rcs_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_i (result_o)
);
